// ----- src/spv_pkg.sv -----
// Shared constants for the sample playback voice: command codes, register
// indexes, field widths, Q15 constants, default parameter values and a clamp.
// No dependencies.
package spv_pkg;

  localparam int DEF_MEM_DEPTH = 65536;
  localparam int DEF_FRAC_BITS = 20;

  localparam int RATIO_W = 24;
  localparam int GLIDE_W = 19;
  localparam int CFG_W   = 19;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 24;

  localparam logic [16:0] ONE_Q15  = 17'd32768;
  localparam logic [15:0] HALF_Q15 = 16'd16384;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_GLIDE = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  localparam logic [2:0] REG_START_OFFSET   = 3'd0;
  localparam logic [2:0] REG_END_POINT      = 3'd1;
  localparam logic [2:0] REG_LOOP_ENABLE    = 3'd2;
  localparam logic [2:0] REG_LOOP_BEGIN     = 3'd3;
  localparam logic [2:0] REG_LOOP_FINISH    = 3'd4;
  localparam logic [2:0] REG_GLIDE_LENGTH   = 3'd5;
  localparam logic [2:0] REG_VELOCITY_DEPTH = 3'd6;
  localparam logic [2:0] REG_SAMPLE_LENGTH  = 3'd7;

  function automatic logic [15:0] clamp_q15(input logic [15:0] v);
    clamp_q15 = (v > 16'd32768) ? 16'd32768 : v;
  endfunction

endpackage

// ----- src/sample_playback_voice_core.sv -----
// Top level of one sampler voice: sample memory, command sequencer,
// interpolation and gain datapath. Uses spv_pkg and spv_divider.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tuser command, s_tdata fields
//  m_*     | out | m_tvalid/m_tready  | m_tdata result fields
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// Sequencing: write, start without glide, stop and silent tick go straight
// to S_OUT. A glide command, or a start that glides, waits in S_GLIDE_DIV
// for one divider pass. A sounding tick runs S_WRAP (and S_WRAP_DIV when the
// loop wraps), S_LIMIT, S_RD0-S_RD2, S_MUL1-S_MUL3, S_SCALE and S_ADV; a tick
// that meets the end point goes from S_LIMIT to S_OUT.
// The shared divider and the single memory read port set this sequence.
// Reset: synchronous rst clears control state and registers; sample memory
// is undefined until written and gets no clearing pass.
// Stalls: s_tready is low while a transaction is in work; a finished
// result waits in the output register while the next input is accepted.
module sample_playback_voice_core #(
  parameter int MEM_DEPTH = spv_pkg::DEF_MEM_DEPTH,
  parameter int FRAC_BITS = spv_pkg::DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // s_tdata, low bit up: write_address[15:0], write_sample[31:16],
  // target_ratio[55:32], note_velocity[71:56], envelope_level[87:72],
  // envelope_active[88], zero fill [95:89]
  input  logic [spv_pkg::IN_W-1:0] s_tdata,
  // s_tuser: command[2:0]
  input  logic [2:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // m_tdata, low bit up: sample_out[15:0], voice_playing[16],
  // note_ended[17], zero fill [23:18]
  output logic [spv_pkg::OUT_W-1:0] m_tdata,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [spv_pkg::CFG_W-1:0] cfg_data
);
  import spv_pkg::*;

  localparam int AW    = $clog2(MEM_DEPTH);
  localparam int POS_W = 16 + FRAC_BITS;
  localparam int V_W   = FRAC_BITS + 18;
  localparam int PR_W  = V_W + 17;
  localparam int SH    = FRAC_BITS + 15;
  localparam int T_W   = PR_W - SH;
  localparam logic signed [PR_W-1:0] RND = PR_W'(1) <<< (FRAC_BITS + 14);

  typedef enum logic [3:0] {
    S_IDLE, S_GLIDE_DIV, S_WRAP, S_WRAP_DIV, S_LIMIT, S_RD0, S_RD1, S_RD2,
    S_MUL1, S_MUL2, S_MUL3, S_SCALE, S_ADV, S_OUT
  } state_t;

  // configuration registers
  logic [15:0]        start_offset, end_point, loop_begin, loop_finish;
  logic               loop_enable;
  logic [GLIDE_W-1:0] glide_length;
  logic [15:0]        velocity_depth;
  logic [16:0]        sample_length;

  // voice state
  state_t                    state;
  logic [POS_W-1:0]          play_position;
  logic [RATIO_W-1:0]        current_ratio, goal_ratio;
  logic signed [RATIO_W:0]   glide_step;
  logic [GLIDE_W-1:0]        glide_left;
  logic [15:0]               velocity_gain;
  logic                      glide_primed, sounding;

  // per-item work registers
  logic [15:0]               env_lvl;
  logic                      step_neg;
  logic [15:0]               rd_idx;
  logic                      has_s1;
  logic [15:0]               gain;
  logic signed [15:0]        s0, s1;
  logic signed [V_W-1:0]     prod1, vsum;
  logic signed [PR_W-1:0]    prod2;
  logic [15:0]               res_sample;
  logic                      res_ended;

  // sample memory
  logic [15:0]               mem [MEM_DEPTH];
  logic [15:0]               rdata;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;

  // shared divider
  logic                      div_start, div_busy, div_done;
  logic [POS_W-1:0]          div_a, div_b, div_q, div_r;

  // input fields
  logic [15:0]        in_waddr, in_wsample, in_vel, in_env;
  logic [RATIO_W-1:0] in_ratio;
  logic               in_eact, accept;

  assign in_waddr   = s_tdata[15:0];
  assign in_wsample = s_tdata[31:16];
  assign in_ratio   = s_tdata[55:32];
  assign in_vel     = s_tdata[71:56];
  assign in_env     = s_tdata[87:72];
  assign in_eact    = s_tdata[88];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;

  // derived control values
  logic [16:0]        total;
  logic [16:0]        limit;
  logic               looping;
  logic [POS_W-1:0]   lb_pos, lf_pos;
  logic [15:0]        pos0;
  logic [FRAC_BITS-1:0] frac;
  logic signed [RATIO_W:0] glide_diff;
  logic [16:0]        vel_comp;
  logic [32:0]        vel_prod;
  logic [32:0]        gain_prod;
  logic signed [T_W-1:0] scaled;
  logic [POS_W:0]     pos_sum;
  logic signed [RATIO_W+1:0] ratio_sum;

  always_comb begin
    if (sample_length == 17'd0) total = 17'd1;
    else if (32'(sample_length) > MEM_DEPTH) total = 17'(MEM_DEPTH);
    else total = sample_length;
    limit   = (end_point != 16'd0) ? {1'b0, end_point} : total - 17'd1;
    looping = loop_enable && (loop_finish > loop_begin);
    lb_pos  = POS_W'(loop_begin) << FRAC_BITS;
    lf_pos  = POS_W'(loop_finish) << FRAC_BITS;
    pos0    = play_position[POS_W-1:FRAC_BITS];
    frac    = play_position[FRAC_BITS-1:0];
    glide_diff = $signed({1'b0, in_ratio}) - $signed({1'b0, current_ratio});
    vel_comp  = ONE_Q15 - {1'b0, clamp_q15(in_vel)};
    vel_prod  = 33'(clamp_q15(velocity_depth)) * 33'(vel_comp) + 33'(HALF_Q15);
    gain_prod = 33'(clamp_q15(env_lvl)) * 33'(velocity_gain) + 33'(HALF_Q15);
    scaled    = T_W'((prod2 + RND) >>> SH);
    pos_sum   = {1'b0, play_position} + (POS_W + 1)'(current_ratio);
    ratio_sum = $signed({2'b00, current_ratio}) + (RATIO_W + 2)'(glide_step);
    rd_addr   = (state == S_RD0) ? AW'(rd_idx) : AW'({1'b0, rd_idx} + 17'd1);
    mem_we    = accept && (s_tuser == CMD_WRITE) && (32'(in_waddr) < MEM_DEPTH);
  end

  // write on accepted write commands; read every cycle, registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(in_waddr)] <= in_wsample;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset   <= '0;
      end_point      <= '0;
      loop_enable    <= 1'b0;
      loop_begin     <= '0;
      loop_finish    <= '0;
      glide_length   <= '0;
      velocity_depth <= 16'd32768;
      sample_length  <= 17'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_OFFSET:   start_offset   <= cfg_data[15:0];
        REG_END_POINT:      end_point      <= cfg_data[15:0];
        REG_LOOP_ENABLE:    loop_enable    <= cfg_data[0];
        REG_LOOP_BEGIN:     loop_begin     <= cfg_data[15:0];
        REG_LOOP_FINISH:    loop_finish    <= cfg_data[15:0];
        REG_GLIDE_LENGTH:   glide_length   <= cfg_data[GLIDE_W-1:0];
        REG_VELOCITY_DEPTH: velocity_depth <= cfg_data[15:0];
        REG_SAMPLE_LENGTH:  sample_length  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  spv_divider #(.W(POS_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      play_position <= '0;
      current_ratio <= '0;
      goal_ratio    <= '0;
      glide_step    <= '0;
      glide_left    <= '0;
      velocity_gain <= '0;
      glide_primed  <= 1'b0;
      sounding      <= 1'b0;
      div_start     <= 1'b0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
    end else begin
      div_start <= 1'b0;
      // drop the output once taken; S_OUT loads the next one itself
      if (m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_sample <= '0;
            res_ended  <= 1'b0;
            env_lvl    <= in_env;
            state      <= S_OUT;
            priority case (s_tuser)
              CMD_START, CMD_GLIDE: begin
                goal_ratio <= in_ratio;
                if (s_tuser == CMD_START) begin
                  play_position <= POS_W'(start_offset) << FRAC_BITS;
                  velocity_gain <= 16'(ONE_Q15 - vel_prod[31:15]);
                  glide_primed  <= 1'b1;
                  sounding      <= 1'b1;
                end
                if (glide_length != '0 &&
                    (s_tuser == CMD_GLIDE || glide_primed)) begin
                  // divide the ratio gap by the glide length
                  glide_left <= glide_length;
                  step_neg   <= glide_diff[RATIO_W];
                  div_a      <= POS_W'(glide_diff[RATIO_W] ? -glide_diff : glide_diff);
                  div_b      <= POS_W'(glide_length);
                  div_start  <= 1'b1;
                  state      <= S_GLIDE_DIV;
                end else begin
                  current_ratio <= in_ratio;
                  glide_left    <= '0;
                end
              end
              CMD_TICK: begin
                if (sounding) begin
                  if (!in_eact) begin
                    sounding  <= 1'b0;
                    res_ended <= 1'b1;
                  end else begin
                    state <= S_WRAP;
                  end
                end
              end
              CMD_STOP: begin
                if (sounding) begin
                  sounding  <= 1'b0;
                  res_ended <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_GLIDE_DIV: begin
          if (div_done) begin
            glide_step <= step_neg ? -$signed((RATIO_W + 1)'(div_q))
                                   : $signed((RATIO_W + 1)'(div_q));
            state <= S_OUT;
          end
        end
        S_WRAP: begin
          if (looping && play_position >= lf_pos) begin
            div_a     <= play_position - lb_pos;
            div_b     <= lf_pos - lb_pos;
            div_start <= 1'b1;
            state     <= S_WRAP_DIV;
          end else begin
            state <= S_LIMIT;
          end
        end
        S_WRAP_DIV: begin
          if (div_done) begin
            play_position <= lb_pos + div_r;
            state         <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          if (!looping && {1'b0, pos0} >= limit) begin
            // end point reached: end the note silently
            sounding  <= 1'b0;
            res_ended <= 1'b1;
            state     <= S_OUT;
          end else begin
            if ({1'b0, pos0} > total - 17'd1) begin
              rd_idx <= 16'(total - 17'd1);
              has_s1 <= 1'b0;
            end else begin
              rd_idx <= pos0;
              has_s1 <= ({1'b0, pos0} + 17'd1) < total;
            end
            gain  <= gain_prod[30:15];
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          s0    <= $signed(rdata);
          state <= S_RD2;
        end
        S_RD2: begin
          s1    <= has_s1 ? $signed(rdata) : 16'sd0;
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod1 <= V_W'((V_W'(s1) - V_W'(s0)) * $signed({1'b0, frac}));
          state <= S_MUL2;
        end
        S_MUL2: begin
          vsum  <= (V_W'(s0) <<< FRAC_BITS) + prod1;
          state <= S_MUL3;
        end
        S_MUL3: begin
          prod2 <= PR_W'(vsum * $signed({1'b0, gain}));
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (scaled > T_W'(32767)) res_sample <= 16'h7fff;
          else if (scaled < -T_W'(32768)) res_sample <= 16'h8000;
          else res_sample <= scaled[15:0];
          state <= S_ADV;
        end
        S_ADV: begin
          // advance position, saturating at the top of the range
          play_position <= pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
          if (glide_left != '0) begin
            glide_left <= glide_left - 1'b1;
            if (glide_left == GLIDE_W'(1)) current_ratio <= goal_ratio;
            else if (ratio_sum < 0) current_ratio <= '0;
            else if (ratio_sum[RATIO_W]) current_ratio <= '1;
            else current_ratio <= ratio_sum[RATIO_W-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, res_ended, sounding, res_sample};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted transaction lowers s_tready in the following cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready) else $error("input accepted while busy");

  // the divider is launched only when idle
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // an ended note never reports as playing and outputs silence
  a_end_silent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[17]) |-> (!m_tdata[16] && m_tdata[15:0] == 16'd0))
    else $error("ended note still playing");

  // sound only comes from a playing voice
  a_sound_playing: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[15:0] != 16'd0) |-> m_tdata[16])
    else $error("sample out while silent");

endmodule

// ----- src/spv_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Shared by loop wrap (modulo) and glide step (quotient). Uses spv_pkg.
module spv_divider #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  import spv_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  dvs;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  assign shifted = {remainder, quotient[W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CW'(W);
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        // keep the partial remainder when the trial goes negative
        if (trial[W]) begin
          remainder <= shifted[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b0};
        end else begin
          remainder <= trial[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
